### sv/midi_note_slot_allocator_defines.svh
// ----------------------------------------------------------------------------
// MIDI note slot allocator assertion macros
// Shared property wrappers clocked on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_SLOT_ALLOCATOR_DEFINES_SVH
`define MIDI_NOTE_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define MNSA_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define MNSA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/mnsa_pkg.sv
// ----------------------------------------------------------------------------
// MIDI note slot allocator package
// Slot record, cell control, sizes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package mnsa_pkg;

  localparam int SLOT_COUNT    = 16;
  localparam int SLOT_IW       = $clog2(SLOT_COUNT);
  localparam int MAX_EVENTS    = 16;
  localparam int EV_CW         = $clog2(MAX_EVENTS + 1);
  localparam int REFRESH_TICKS = 96;
  localparam int NOTE_SHIFT    = 12;

  localparam logic KIND_ON  = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_NOTE = 1'b1;

  typedef struct packed {
    logic              busy;
    logic [6:0]        note;
    logic signed [8:0] ticks;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_PUT_ON
  } state_t;

endpackage

`default_nettype wire

### sv/mnsa_cell.sv
// ----------------------------------------------------------------------------
// Slot cell
// Holds one note slot; shifts from its neighbor or loads a new allocation.
// ----------------------------------------------------------------------------
`default_nettype none

module mnsa_cell (
  input  wire                       clk,
  input  wire                       rst,
  input  wire mnsa_pkg::cell_ctl_t  ctl,
  input  wire mnsa_pkg::slot_t      shift_in,
  input  wire mnsa_pkg::slot_t      load_val,
  output mnsa_pkg::slot_t           q
);
  import mnsa_pkg::*;

  logic              busy;
  logic [6:0]        note;
  logic signed [8:0] ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      ticks <= -9'sd1;
    end else if (ctl.load) begin
      busy  <= load_val.busy;
      ticks <= load_val.ticks;
    end else if (ctl.shift) begin
      busy  <= shift_in.busy;
      ticks <= shift_in.ticks;
    end
  end

  // note is used only once its slot is busy, so it needs no reset
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      note <= load_val.note;
    end else if (ctl.shift) begin
      note <= shift_in.note;
    end
  end

  assign q = '{busy: busy, note: note, ticks: ticks};

endmodule

`default_nettype wire

### sv/midi_note_slot_allocator.sv
// ----------------------------------------------------------------------------
// MIDI note slot allocator
// Voice allocator with note stealing over a rotating row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with action/note/velocity/hold_ticks while busy is low;
//   the request is taken at that edge and busy rises the next cycle.
//   action 0 is a tempo tick, action 1 a note on request.
//   Every request rotates the 16-cell slot row once around, one slot per
//   cycle through the head logic; a stolen slot gives a note off, then note on.
//   Events come out with valid high for one cycle each; last marks the
//   final event of a request. A request may give no events at all.
//   The receiver cannot stall: each event is taken when valid is high.
//   The user writes midi_channel (cfg_we/cfg_data) only while busy is low;
//   the block does not enforce this. Reset (rst, synchronous) frees all
//   slots and clears the channel to 0; ready the cycle after reset drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midi_note_slot_allocator_defines.svh"

module midi_note_slot_allocator (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire  [3:0]        cfg_data,
  input  wire               start,
  output logic              busy,
  input  wire               action,
  input  wire  [6:0]        note,
  input  wire  [6:0]        velocity,
  input  wire  [7:0]        hold_ticks,
  output logic              valid,
  output logic              kind,
  output logic signed [7:0] out_note,
  output logic [6:0]        out_velocity,
  output logic [3:0]        out_channel,
  output logic              last
);
  import mnsa_pkg::*;

  state_t state, state_next;

  logic [3:0] midi_channel;

  logic       req_action;
  logic [6:0] req_note;
  logic [6:0] req_vel;
  logic [7:0] req_hold;

  logic [SLOT_IW-1:0] idx;
  logic               held;
  logic               found_free;
  logic [SLOT_IW-1:0] free_idx;
  logic [SLOT_IW-1:0] victim_idx;
  logic [6:0]         victim_note;
  logic signed [8:0]  lowest;
  logic               pend_valid;
  logic [6:0]         pend_note;
  logic [EV_CW-1:0]   ev_count;

  slot_t     cell_q   [SLOT_COUNT];
  slot_t     cell_in  [SLOT_COUNT];
  cell_ctl_t cell_ctl [SLOT_COUNT];
  slot_t     head, head_upd, load_val;

  logic              expire, match, scan_last, load_go;
  logic              ev_room;
  logic signed [8:0] tick_dec;
  logic [SLOT_IW-1:0] load_idx;

  logic       emit, emit_kind, emit_last;
  logic [6:0] emit_note, emit_vel;

  // --------------------------------------------------------------------------
  // Slot row: cell 0 is the head, the updated head re-enters at the tail
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    if (i < SLOT_COUNT - 1) begin : g_mid
      assign cell_in[i] = cell_q[i + 1];
    end else begin : g_tail
      assign cell_in[i] = head_upd;
    end

    assign cell_ctl[i] = '{shift: (state == ST_SCAN),
                           load:  load_go && (load_idx == SLOT_IW'(i))};

    mnsa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl[i]),
      .shift_in (cell_in[i]),
      .load_val (load_val),
      .q        (cell_q[i])
    );
  end

  assign head      = cell_q[0];
  assign tick_dec  = head.ticks - 9'sd1;
  assign scan_last = (idx == SLOT_IW'(SLOT_COUNT - 1));
  assign ev_room   = (ev_count < EV_CW'(MAX_EVENTS));
  assign load_val  = '{busy: 1'b1, note: req_note, ticks: $signed({1'b0, req_hold})};
  assign load_idx  = found_free ? free_idx : victim_idx;

  always_comb begin
    head_upd = head;
    expire   = 1'b0;
    match    = 1'b0;
    if (req_action == ACT_TICK) begin
      if (head.busy) begin
        head_upd.ticks = tick_dec;
        if (tick_dec <= 9'sd0) begin
          expire        = 1'b1;
          head_upd.busy = 1'b0;
        end
      end
    end else if (head.busy && (head.note == req_note)) begin
      match          = 1'b1;
      head_upd.ticks = 9'(REFRESH_TICKS);
    end
  end

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = ST_FINISH;
      ST_FINISH: begin
        if (req_action == ACT_NOTE && !held && !found_free) begin
          state_next = ST_PUT_ON;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PUT_ON: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    load_go   = 1'b0;
    emit      = 1'b0;
    emit_kind = KIND_OFF;
    emit_note = pend_note;
    emit_vel  = 7'd0;
    emit_last = 1'b0;
    case (state)
      ST_SCAN: begin
        // a new expiry releases the one held back
        if (req_action == ACT_TICK && expire && ev_room && pend_valid) begin
          emit = 1'b1;
        end
      end
      ST_FINISH: begin
        if (req_action == ACT_TICK) begin
          emit      = pend_valid;
          emit_last = 1'b1;
        end else if (!held) begin
          load_go = 1'b1;
          emit    = 1'b1;
          if (found_free) begin
            emit_kind = KIND_ON;
            emit_note = req_note;
            emit_vel  = req_vel;
            emit_last = 1'b1;
          end else begin
            emit_note = victim_note;
          end
        end
      end
      ST_PUT_ON: begin
        emit      = 1'b1;
        emit_kind = KIND_ON;
        emit_note = req_note;
        emit_vel  = req_vel;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      midi_channel <= 4'd0;
      valid        <= 1'b0;
    end else begin
      state <= state_next;
      valid <= emit;
      if (cfg_we) begin
        midi_channel <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      held       <= 1'b0;
      found_free <= 1'b0;
      pend_valid <= 1'b0;
      ev_count   <= '0;
    end else if (state == ST_IDLE && start) begin
      idx        <= '0;
      held       <= 1'b0;
      found_free <= 1'b0;
      pend_valid <= 1'b0;
      ev_count   <= '0;
    end else if (state == ST_SCAN) begin
      idx <= idx + SLOT_IW'(1);
      if (req_action == ACT_TICK) begin
        if (expire && ev_room) begin
          pend_valid <= 1'b1;
          ev_count   <= ev_count + EV_CW'(1);
        end
      end else begin
        if (match) held <= 1'b1;
        if (!head.busy && !found_free) found_free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req_action <= action;
      req_note   <= note;
      req_vel    <= velocity;
      req_hold   <= hold_ticks;
    end
    if (state == ST_SCAN) begin
      if (req_action == ACT_TICK && expire && ev_room) begin
        pend_note <= head.note;
      end
      if (!head.busy && !found_free) begin
        free_idx <= idx;
      end
      // fewest ticks left, lowest index on a tie
      if (idx == '0 || head.ticks < lowest) begin
        lowest      <= head.ticks;
        victim_idx  <= idx;
        victim_note <= head.note;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind         <= emit_kind;
      out_note     <= $signed({1'b0, emit_note}) - 8'(NOTE_SHIFT);
      out_velocity <= emit_vel;
      out_channel  <= midi_channel;
      last         <= emit_last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MNSA_ASSERT_SAME(a_last_ends_request, valid && last, !busy, "last event before idle")
  `MNSA_ASSERT_SAME(a_note_on_is_last, valid && (kind == KIND_ON), last, "note on not last")
  `MNSA_ASSERT_SAME(a_put_on_after_finish, state == ST_PUT_ON, $past(state) == ST_FINISH,
                    "steal note on out of order")
  `MNSA_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy, "request not taken")
  `MNSA_ASSERT_SAME(a_event_cap, 1'b1, ev_count <= EV_CW'(MAX_EVENTS), "event count overrun")

endmodule

`default_nettype wire
